/* rtl/button_press_classifier_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button press classifier unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpc assertion failed");

`endif

/* rtl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, register indexes and reset values for the button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned REG_WIDTH   = 16;
  localparam int unsigned INDEX_WIDTH = 2;

  localparam logic [REG_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [REG_WIDTH-1:0] SHORT_RESET    = 16'd150;
  localparam logic [REG_WIDTH-1:0] LONG_RESET     = 16'd700;
  localparam logic [REG_WIDTH-1:0] ULTRA_RESET    = 16'd2500;

  localparam logic [INDEX_WIDTH-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_SHORT    = 2'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_LONG     = 2'd2;
  localparam logic [INDEX_WIDTH-1:0] REG_ULTRA    = 2'd3;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2,
    EV_ULTRA = 2'd3
  } press_event_t;

  typedef struct packed {
    logic [REG_WIDTH-1:0] debounce_ticks;
    logic [REG_WIDTH-1:0] short_ticks;
    logic [REG_WIDTH-1:0] long_ticks;
    logic [REG_WIDTH-1:0] ultra_ticks;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/button_press_classifier_unit.sv */
// ----------------------------------------------------------------------------
// button_press_classifier_unit
// Debounces a sampled button level and classifies each press by duration.
// ----------------------------------------------------------------------------
// Every input transfer is one sample tick and yields exactly one result in the
// cycle after it: 0 none, 1 short, 2 long or 3 ultra long press, reported on
// the tick whose sample completes a debounced release. One sample is taken in
// every cycle that in_tvalid is high; the single result register takes a new
// sample in the same cycle as its held result leaves, and holds input back
// only while a result waits on out_tready. The user writes threshold
// registers via the cfg port while no transfer is in flight (not enforced).
`default_nettype none

module button_press_classifier_unit #(
  parameter int unsigned COUNT_WIDTH = bpc_pkg::COUNT_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // Bit 0: raw_pressed.
  input  wire logic [7:0]                      in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // Bits 1:0: press_event.
  output logic [7:0]                           out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [bpc_pkg::INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [bpc_pkg::REG_WIDTH-1:0]   cfg_wdata
);

  bpc_pkg::cfg_t         cfg;
  bpc_pkg::press_event_t press_event;
  bpc_pkg::press_event_t out_event;
  logic                  step;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .raw_pressed (in_tdata[0]),
    .cfg         (cfg),
    .press_event (press_event)
  );

  bpc_out_reg u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .press_event (press_event),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_event   (out_event),
    .step        (step)
  );

  assign out_tdata = {6'b0, out_event};

endmodule

`default_nettype wire

/* rtl/bpc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Holds the debounce and press duration threshold registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bpc_pkg::INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [bpc_pkg::REG_WIDTH-1:0]     cfg_wdata,
  output bpc_pkg::cfg_t                          cfg
);

  bpc_pkg::cfg_t cfg_r;
  bpc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::REG_DEBOUNCE: cfg_nxt.debounce_ticks = cfg_wdata;
        bpc_pkg::REG_SHORT:    cfg_nxt.short_ticks    = cfg_wdata;
        bpc_pkg::REG_LONG:     cfg_nxt.long_ticks     = cfg_wdata;
        bpc_pkg::REG_ULTRA:    cfg_nxt.ultra_ticks    = cfg_wdata;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= bpc_pkg::DEBOUNCE_RESET;
      cfg_r.short_ticks    <= bpc_pkg::SHORT_RESET;
      cfg_r.long_ticks     <= bpc_pkg::LONG_RESET;
      cfg_r.ultra_ticks    <= bpc_pkg::ULTRA_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/bpc_core.sv */
// ----------------------------------------------------------------------------
// bpc_core
// Debounce and press duration state, updated once per transfer, with the
// combinational classification of the press on a debounced release.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_core #(
  parameter int unsigned COUNT_WIDTH = bpc_pkg::COUNT_WIDTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic           raw_pressed,
  input  wire bpc_pkg::cfg_t  cfg,
  output bpc_pkg::press_event_t press_event
);

  localparam int unsigned CMP_WIDTH =
    (COUNT_WIDTH > bpc_pkg::REG_WIDTH) ? COUNT_WIDTH : bpc_pkg::REG_WIDTH;

  logic                   last_raw_r, last_raw_nxt;
  logic [COUNT_WIDTH-1:0] quiet_r, quiet_nxt;
  logic                   deb_r, deb_nxt;
  logic [COUNT_WIDTH-1:0] dur_r, dur_nxt;
  logic                   await_r, await_nxt;

  logic [COUNT_WIDTH-1:0] dur_inc;
  logic                   accept_level;

  always_comb begin
    dur_inc = dur_r;
    if (deb_r && (dur_r != {COUNT_WIDTH{1'b1}})) begin
      dur_inc = dur_r + 1'b1;
    end

    last_raw_nxt = raw_pressed;
    if (raw_pressed != last_raw_r) begin
      quiet_nxt = '0;
    end else if (quiet_r == {COUNT_WIDTH{1'b1}}) begin
      quiet_nxt = quiet_r;
    end else begin
      quiet_nxt = quiet_r + 1'b1;
    end

    accept_level = (CMP_WIDTH'(quiet_nxt) > CMP_WIDTH'(cfg.debounce_ticks))
                   && (deb_r != raw_pressed);

    deb_nxt     = deb_r;
    dur_nxt     = dur_inc;
    await_nxt   = await_r;
    press_event = bpc_pkg::EV_NONE;

    if (accept_level) begin
      deb_nxt = raw_pressed;
      if (raw_pressed) begin
        dur_nxt   = '0;
        await_nxt = 1'b1;
      end else if (await_r) begin
        await_nxt = 1'b0;
        priority if (CMP_WIDTH'(dur_inc) >= CMP_WIDTH'(cfg.ultra_ticks)) begin
          press_event = bpc_pkg::EV_ULTRA;
        end else if (CMP_WIDTH'(dur_inc) >= CMP_WIDTH'(cfg.long_ticks)) begin
          press_event = bpc_pkg::EV_LONG;
        end else if (CMP_WIDTH'(dur_inc) >= CMP_WIDTH'(cfg.short_ticks)) begin
          press_event = bpc_pkg::EV_SHORT;
        end else begin
          press_event = bpc_pkg::EV_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b0;
      quiet_r    <= '0;
      deb_r      <= 1'b0;
      dur_r      <= '0;
      await_r    <= 1'b0;
    end else if (step) begin
      last_raw_r <= last_raw_nxt;
      quiet_r    <= quiet_nxt;
      deb_r      <= deb_nxt;
      dur_r      <= dur_nxt;
      await_r    <= await_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/bpc_out_reg.sv */
// ----------------------------------------------------------------------------
// bpc_out_reg
// Result register of the stream output, with the ready logic that lets a new
// transfer in when it is empty or its held result leaves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire bpc_pkg::press_event_t press_event,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output bpc_pkg::press_event_t      out_event,
  output logic                       step
);

  logic                  valid_r, valid_nxt;
  bpc_pkg::press_event_t event_r, event_nxt;

  always_comb begin
    in_tready = !valid_r || out_tready;
    step      = in_tvalid && in_tready;
    valid_nxt = valid_r;
    event_nxt = event_r;
    if (step) begin
      valid_nxt = 1'b1;
      event_nxt = press_event;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    event_r <= event_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_event  = event_r;

endmodule

`default_nettype wire

/* rtl/bpc_checker.sv */
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the button press classifier unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_unit_macros.svh"

module bpc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_tvalid && in_tready && (in_tdata == in_tdata);
  assign out_stall = out_tvalid && !out_tready;

  `BPC_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_tvalid)
  `BPC_ASSERT_SAME(a_ready_when_free, !out_tvalid || out_tready, in_tready)
  `BPC_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[7:2] == 6'b0)
  `BPC_ASSERT_NEXT(a_stall_holds, out_stall, out_tvalid && $stable(out_tdata))

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (.*);

`default_nettype wire

/* tb/sv/press_event_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// press_event_monitor
// Observes the sample, event and register channels of the button press
// classifier, tracks its debounce and duration state, and checks every event
// transfer against the oldest predicted event.
// ----------------------------------------------------------------------------
module press_event_monitor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  // Bit 0: raw_pressed.
  input  wire logic [7:0]                      in_tdata,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  // Bits 1:0: press_event.
  input  wire logic [7:0]                      out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [bpc_pkg::INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [bpc_pkg::REG_WIDTH-1:0]   cfg_wdata,
  output int                                   mismatches,
  output int                                   outstanding
);

  typedef logic [bpc_pkg::COUNT_WIDTH-1:0] tick_count_t;
  localparam tick_count_t COUNT_CEIL = '1;

  bpc_pkg::cfg_t          limits;
  logic                   prev_raw;
  logic                   settled;
  logic                   armed;
  tick_count_t            quiet_run;
  tick_count_t            held_ticks;
  bpc_pkg::press_event_t  expected_events[$];
  int                     fails = 0;

  assign mismatches = fails;

  task automatic advance_tick(input logic raw, output bpc_pkg::press_event_t ev);
    ev = bpc_pkg::EV_NONE;
    if (settled && held_ticks != COUNT_CEIL) held_ticks = held_ticks + 1'b1;
    if (raw != prev_raw) begin
      prev_raw  = raw;
      quiet_run = '0;
    end else if (quiet_run != COUNT_CEIL) begin
      quiet_run = quiet_run + 1'b1;
    end
    if (quiet_run > limits.debounce_ticks && settled != raw) begin
      settled = raw;
      if (raw) begin
        held_ticks = '0;
        armed      = 1'b1;
      end else if (armed) begin
        armed = 1'b0;
        if (held_ticks >= limits.ultra_ticks) ev = bpc_pkg::EV_ULTRA;
        else if (held_ticks >= limits.long_ticks) ev = bpc_pkg::EV_LONG;
        else if (held_ticks >= limits.short_ticks) ev = bpc_pkg::EV_SHORT;
      end
    end
  endtask

  always @(posedge clk) begin
    bpc_pkg::press_event_t predicted;
    bpc_pkg::press_event_t oldest;
    logic [1:0]            seen;
    if (!rst_n) begin
      limits.debounce_ticks = bpc_pkg::DEBOUNCE_RESET;
      limits.short_ticks    = bpc_pkg::SHORT_RESET;
      limits.long_ticks     = bpc_pkg::LONG_RESET;
      limits.ultra_ticks    = bpc_pkg::ULTRA_RESET;
      prev_raw   = 1'b0;
      settled    = 1'b0;
      armed      = 1'b0;
      quiet_run  = '0;
      held_ticks = '0;
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bpc_pkg::REG_DEBOUNCE: limits.debounce_ticks = cfg_wdata;
          bpc_pkg::REG_SHORT:    limits.short_ticks    = cfg_wdata;
          bpc_pkg::REG_LONG:     limits.long_ticks     = cfg_wdata;
          bpc_pkg::REG_ULTRA:    limits.ultra_ticks    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        advance_tick(in_tdata[0], predicted);
        expected_events.push_back(predicted);
      end
      if (out_tvalid && out_tready) begin
        seen = out_tdata[1:0];
        if (expected_events.size() == 0) begin
          $display("%0t: press_event expected none actual %0d", $time, seen);
          fails++;
        end else begin
          oldest = expected_events.pop_front();
          if (seen !== oldest) begin
            $display("%0t: press_event expected %0d actual %0d", $time, oldest, seen);
            fails++;
          end
        end
      end
    end
    outstanding <= expected_events.size();
  end

endmodule

/* tb/sv/button_press_classifier_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_unit_tb
// Drives sample ticks through the button press classifier under several
// threshold settings, including a debounce threshold that never settles and
// unordered thresholds, with random gaps and back-pressure, and reports the
// monitor's verdict.
// ----------------------------------------------------------------------------
module button_press_classifier_unit_tb;

  localparam int unsigned STALL_LIMIT = 1000;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b1;
  logic [7:0]                      out_tdata;
  logic                            cfg_we;
  logic [bpc_pkg::INDEX_WIDTH-1:0] cfg_index;
  logic [bpc_pkg::REG_WIDTH-1:0]   cfg_wdata;
  int                              mismatches;
  int                              outstanding;
  bit                              idle_en = 1'b1;
  int unsigned                     stall_left = 0;
  int unsigned                     quiet_cycles = 0;

  button_press_classifier_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  press_event_monitor u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("button_press_classifier_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic level);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_level(input logic level, input int count);
    repeat (count) send_sample(level);
  endtask

  task automatic press_cycle(input int hold, input int gap);
    send_level(1'b1, hold);
    send_level(1'b0, gap);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_limits(input logic [15:0] deb, input logic [15:0] s,
                                input logic [15:0] l, input logic [15:0] u);
    cfg_we    <= 1'b1;
    cfg_index <= bpc_pkg::REG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= bpc_pkg::REG_SHORT;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= bpc_pkg::REG_LONG;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_index <= bpc_pkg::REG_ULTRA;
    cfg_wdata <= u;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly clean presses with random hold times, mixed with bouncing samples.
  task automatic random_presses(input int shape_deb, input int span, input int n_items);
    int sent;
    int hold;
    int gap;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        hold = shape_deb + 1 + $urandom_range(0, span);
        gap  = shape_deb + 1 + $urandom_range(0, 3);
        press_cycle(hold, gap);
        sent += hold + gap;
      end else begin
        burst = $urandom_range(1, shape_deb + 2);
        for (int j = 0; j < burst; j++) send_sample(1'($urandom_range(0, 1)));
        sent += burst;
      end
    end
  endtask

  initial begin
    int          deb;
    int unsigned s;
    int unsigned l;
    int unsigned u;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= bpc_pkg::REG_DEBOUNCE;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset thresholds: one bounced press long enough for a short event.
    send_level(1'b0, 3);
    send_level(1'b1, 2);
    send_level(1'b0, 22);
    press_cycle(160, 25);
    drain();

    program_limits(16'd0, 16'd2, 16'd4, 16'd6);
    send_level(1'b0, 2);
    press_cycle(2, 2);
    press_cycle(3, 2);
    press_cycle(5, 2);
    press_cycle(8, 2);
    send_level(1'b1, 1);
    send_level(1'b0, 2);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      idle_en = ($urandom_range(0, 3) != 0);
      deb = $urandom_range(0, 3);
      s = $urandom_range(1, 4);
      l = s + $urandom_range(1, 5);
      u = l + $urandom_range(1, 6);
      case (phase)
        0: program_limits(16'(deb), 16'(s), 16'(l), 16'(u));
        1: program_limits(16'(deb), 16'(u), 16'(l), 16'(s));
        2: program_limits(16'(deb), 16'd0, 16'($urandom_range(0, 5)),
                          16'($urandom_range(0, 10)));
        3: program_limits(16'd0, 16'(s), 16'(l), 16'(u));
        4: program_limits(16'(deb), 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: program_limits(16'hFFFF, 16'(s), 16'(l), 16'(u));
      endcase
      random_presses(deb, u + 3, 20);
      drain();
    end

    // Last part runs without gaps and starts no new back-pressure stalls.
    idle_en = 1'b0;
    program_limits(16'd1, 16'd1, 16'd2, 16'd3);
    press_cycle(2, 3);
    press_cycle(4, 3);
    press_cycle(6, 3);
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("button_press_classifier_unit regression: pass");
    end else begin
      $display("button_press_classifier_unit regression: fail");
    end
    $finish;
  end

endmodule
